/* hw/rtl/stfp_pkg.sv */
// Shared types, constants and helper functions of the stream table block.
// Used by the entry memory, the top level, the configuration helper interface and the testbench.
package stfp_pkg;

    localparam int STREAMS    = 64;
    localparam int IDX_W      = (STREAMS > 1) ? $clog2(STREAMS) : 1;
    localparam int CNT_W      = $clog2(STREAMS + 1) + 1;
    localparam int LIM_W      = (CNT_W > 7) ? CNT_W : 7;
    localparam int WIN_W      = 31;
    localparam int ID_W       = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [WIN_W-1:0] CONN_WIN_RESET    = 31'd65535;
    localparam logic [WIN_W-1:0] INIT_WIN_RESET    = 31'd65535;
    localparam logic [6:0]       MAX_STREAMS_RESET = 7'd64;
    localparam logic [7:0]       DEFAULT_WEIGHT    = 8'd16;

    // Stream states
    localparam logic [2:0] SS_IDLE          = 3'd0;
    localparam logic [2:0] SS_OPEN          = 3'd1;
    localparam logic [2:0] SS_HALF_LOCAL    = 3'd2;
    localparam logic [2:0] SS_HALF_REMOTE   = 3'd3;
    localparam logic [2:0] SS_CLOSED        = 3'd4;

    typedef enum logic [3:0] {
        OP_CREATE        = 4'd0,
        OP_REMOVE        = 4'd1,
        OP_SET_STATE     = 4'd2,
        OP_SET_PRIO      = 4'd3,
        OP_SEND_UPD      = 4'd4,
        OP_RECV_UPD      = 4'd5,
        OP_SEND_USE      = 4'd6,
        OP_RECV_USE      = 4'd7,
        OP_CONN_SEND_UPD = 4'd8,
        OP_CONN_RECV_UPD = 4'd9,
        OP_CONN_SEND_USE = 4'd10,
        OP_CONN_RECV_USE = 4'd11,
        OP_SCHEDULE      = 4'd12,
        OP_LOOKUP        = 4'd13
    } op_t;

    typedef enum logic [2:0] {
        STS_OK          = 3'd0,
        STS_FLOW_ERR    = 3'd1,
        STS_DUPLICATE   = 3'd2,
        STS_TOO_MANY    = 3'd3,
        STS_NOT_FOUND   = 3'd4,
        STS_NOTHING     = 3'd5
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_STREAMS  = 2'd0,
        CFG_INIT_WINDOW  = 2'd1,
        CFG_CONN_WINDOW  = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_SCHED_BEST,
        S_SCHED_DROP,
        S_EXEC
    } fsm_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [2:0]       state;
        logic [WIN_W-1:0] send_win;
        logic [WIN_W-1:0] recv_win;
        logic [ID_W-1:0]  dep;
        logic [7:0]       weight;
        logic             excl;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } ram_wr_t;

    // True when entry a is served before entry b.
    function automatic logic ranks_ahead(entry_t a, entry_t b);
        logic r;
        if (a.dep != b.dep) begin
            r = (a.dep < b.dep);
        end else if (a.weight != b.weight) begin
            r = (a.weight > b.weight);
        end else if (a.excl != b.excl) begin
            r = a.excl;
        end else begin
            r = (a.id < b.id);
        end
        return r;
    endfunction

    function automatic logic can_send(entry_t e);
        return (e.state == SS_OPEN) || (e.state == SS_HALF_REMOTE);
    endfunction

endpackage

/* hw/rtl/stfp_cmd_if.sv */
// Command channel of the stream table block: valid, ready and the command item.
// Depends on nothing else.
interface stfp_cmd_if;
    logic        valid;
    logic        ready;
    logic [3:0]  op;
    logic [30:0] flow_id;
    logic [30:0] amount;
    logic [2:0]  new_state;
    logic [30:0] dependency;
    logic [7:0]  weight;
    logic        exclusive;

    modport source (output valid, op, flow_id, amount, new_state, dependency, weight,
                    exclusive, input ready);
    modport sink (input valid, op, flow_id, amount, new_state, dependency, weight,
                  exclusive, output ready);
endinterface

/* hw/rtl/stfp_res_if.sv */
// Result channel of the stream table block: valid, ready and the result item.
// Depends on nothing else.
interface stfp_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [30:0] result_id;
    logic [2:0]  result_state;
    logic [30:0] send_window;
    logic [30:0] recv_window;

    modport source (output valid, status, result_id, result_state, send_window, recv_window,
                    input ready);
    modport sink (input valid, status, result_id, result_state, send_window, recv_window,
                  output ready);
endinterface

/* hw/rtl/stfp_table.sv */
// Entry memory of the stream table: one write port and one registered read port.
// Depends on stfp_pkg.
module stfp_table (
    input  logic                          clk,
    input  stfp_pkg::ram_wr_t             wr,
    input  logic [stfp_pkg::IDX_W-1:0]    rd_addr,
    output stfp_pkg::entry_t              rd_data
);
    import stfp_pkg::*;

    entry_t mem [STREAMS];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* hw/rtl/stream_table_flow_priority_core.sv */
// Stream table with flow-control windows and a priority scheduler.
// Commands are handled one at a time: create, remove, update and lookup each sweep the
// entry memory once, schedule sweeps it twice and connection window commands need no sweep.
// The sweep reads the entry memory through its registered read port, one entry a cycle.
// Reset clears all valid and queued bits, the stream count and the rebuild mark, and loads
// the registers and connection windows with their reset values; no clearing pass is needed.
module stream_table_flow_priority_core (
    input  logic                              clk,
    input  logic                              rst_n,
    stfp_cmd_if.sink                          cmd,
    stfp_res_if.source                        res,
    input  logic                              cfg_write,
    input  logic [stfp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [stfp_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import stfp_pkg::*;

    // Control state
    fsm_t                 state_reg, state_next;
    logic [CNT_W-1:0]     issue_cnt_reg;
    logic [IDX_W-1:0]     rd_idx_reg;
    logic                 rd_vld_reg;
    logic [STREAMS-1:0]   valid_reg;
    logic [STREAMS-1:0]   queued_reg;
    logic [CNT_W-1:0]     stream_count_reg;
    logic                 dirty_reg;
    logic [WIN_W-1:0]     conn_send_reg;
    logic [WIN_W-1:0]     conn_recv_reg;
    logic [6:0]           max_streams_reg;
    logic [WIN_W-1:0]     init_win_reg;
    logic                 res_valid_reg;

    // Command held for the whole of its processing
    op_t                  op_reg;
    logic [ID_W-1:0]      id_reg;
    logic [WIN_W-1:0]     amount_reg;
    logic [2:0]           nst_reg;
    logic [ID_W-1:0]      dep_reg;
    logic [7:0]           wt_reg;
    logic                 ex_reg;

    // Sweep results
    logic                 hit_reg;
    logic [IDX_W-1:0]     hit_idx_reg;
    entry_t               row_reg;
    logic                 free_found_reg;
    logic [IDX_W-1:0]     free_idx_reg;
    logic                 best_found_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    entry_t               best_row_reg;

    // Result payload
    logic [2:0]           res_status_reg;
    logic [ID_W-1:0]      res_id_reg;
    logic [2:0]           res_state_reg;
    logic [WIN_W-1:0]     res_send_reg;
    logic [WIN_W-1:0]     res_recv_reg;

    // Memory access
    ram_wr_t              ram_wr;
    entry_t               rd_data;
    logic [IDX_W-1:0]     rd_addr;

    logic                 sweeping;
    logic                 issue_en;
    logic                 sweep_last;
    logic                 cmd_ready;
    logic                 exec_go;
    logic                 vbit;
    logic                 qbit;

    stfp_table u_table (
        .clk     (clk),
        .wr      (ram_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // The sweep issues one read a cycle; the data and its index come back in the next cycle.
    assign sweeping   = (state_reg == S_FIND) || (state_reg == S_SCHED_BEST)
                        || (state_reg == S_SCHED_DROP);
    assign issue_en   = sweeping && (issue_cnt_reg < CNT_W'(STREAMS));
    assign rd_addr    = issue_cnt_reg[IDX_W-1:0];
    assign sweep_last = rd_vld_reg && (rd_idx_reg == IDX_W'(STREAMS - 1));
    assign vbit       = valid_reg[rd_idx_reg];
    assign qbit       = queued_reg[rd_idx_reg];
    assign exec_go    = (state_reg == S_EXEC) && (!res_valid_reg || res.ready);

    assign cmd.ready        = cmd_ready;
    assign res.valid        = res_valid_reg;
    assign res.status       = res_status_reg;
    assign res.result_id    = res_id_reg;
    assign res.result_state = res_state_reg;
    assign res.send_window  = res_send_reg;
    assign res.recv_window  = res_recv_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        cmd_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd.valid)
                begin
                    case (op_t'(cmd.op))
                        OP_CREATE, OP_REMOVE, OP_SET_STATE, OP_SET_PRIO, OP_SEND_UPD,
                        OP_RECV_UPD, OP_SEND_USE, OP_RECV_USE, OP_LOOKUP:
                            state_next = S_FIND;
                        OP_SCHEDULE:
                            state_next = S_SCHED_BEST;
                        default:
                            state_next = S_EXEC;
                    endcase
                end
            end
            S_FIND:
            begin
                if (sweep_last)
                begin
                    state_next = S_EXEC;
                end
            end
            S_SCHED_BEST:
            begin
                if (sweep_last)
                begin
                    state_next = S_SCHED_DROP;
                end
            end
            S_SCHED_DROP:
            begin
                if (sweep_last)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Execution of the command once all sweeps are done
    logic [LIM_W-1:0]  lim_count;
    logic              table_full;
    logic [WIN_W-1:0]  win_sel;
    logic [WIN_W:0]    win_sum;
    logic              grow_ok;
    logic              shrink_ok;
    logic [WIN_W-1:0]  win_diff;
    status_t           ex_status;
    logic              ex_report;
    logic              ex_conn;
    logic              ex_create;
    logic              ex_remove;
    logic              ex_dirty;
    entry_t            ex_row;
    entry_t            new_row;
    logic [WIN_W-1:0]  conn_send_next;
    logic [WIN_W-1:0]  conn_recv_next;

    assign lim_count  = LIM_W'(stream_count_reg);
    assign table_full = (lim_count >= LIM_W'(max_streams_reg))
                        || (lim_count >= LIM_W'(STREAMS)) || !free_found_reg;

    always_comb
    begin
        case (op_reg)
            OP_SEND_UPD, OP_SEND_USE:           win_sel = row_reg.send_win;
            OP_RECV_UPD, OP_RECV_USE:           win_sel = row_reg.recv_win;
            OP_CONN_SEND_UPD, OP_CONN_SEND_USE: win_sel = conn_send_reg;
            default:                            win_sel = conn_recv_reg;
        endcase
    end

    assign win_sum   = {1'b0, win_sel} + {1'b0, amount_reg};
    assign grow_ok   = !win_sum[WIN_W];
    assign shrink_ok = (amount_reg <= win_sel);
    assign win_diff  = win_sel - amount_reg;

    always_comb
    begin
        new_row.id       = id_reg;
        new_row.state    = SS_IDLE;
        new_row.send_win = init_win_reg;
        new_row.recv_win = init_win_reg;
        new_row.dep      = '0;
        new_row.weight   = DEFAULT_WEIGHT;
        new_row.excl     = 1'b0;
    end

    always_comb
    begin
        ex_status      = STS_OK;
        ex_report      = 1'b0;
        ex_conn        = 1'b0;
        ex_create      = 1'b0;
        ex_remove      = 1'b0;
        ex_dirty       = 1'b0;
        ex_row         = row_reg;
        conn_send_next = conn_send_reg;
        conn_recv_next = conn_recv_reg;
        ram_wr.en      = 1'b0;
        ram_wr.addr    = hit_idx_reg;
        ram_wr.data    = row_reg;
        case (op_reg)
            OP_CREATE:
            begin
                if (hit_reg)
                begin
                    ex_status = STS_DUPLICATE;
                    ex_report = 1'b1;
                end else if (table_full)
                begin
                    ex_status = STS_TOO_MANY;
                end else
                begin
                    ex_row      = new_row;
                    ex_report   = 1'b1;
                    ex_create   = 1'b1;
                    ram_wr.en   = exec_go;
                    ram_wr.addr = free_idx_reg;
                end
            end
            OP_REMOVE:
            begin
                if (hit_reg)
                begin
                    ex_report = 1'b1;
                    ex_remove = 1'b1;
                    ex_dirty  = 1'b1;
                end else
                begin
                    ex_status = STS_NOT_FOUND;
                end
            end
            OP_SET_STATE:
            begin
                if (hit_reg)
                begin
                    ex_row.state = (nst_reg > SS_CLOSED) ? SS_CLOSED : nst_reg;
                    ex_report    = 1'b1;
                    ram_wr.en    = exec_go;
                end else
                begin
                    ex_status = STS_NOT_FOUND;
                end
            end
            OP_SET_PRIO:
            begin
                if (hit_reg)
                begin
                    ex_row.dep    = dep_reg;
                    ex_row.weight = wt_reg;
                    ex_row.excl   = ex_reg;
                    ex_report     = 1'b1;
                    ex_dirty      = 1'b1;
                    ram_wr.en     = exec_go;
                end else
                begin
                    ex_status = STS_NOT_FOUND;
                end
            end
            OP_SEND_UPD, OP_RECV_UPD, OP_SEND_USE, OP_RECV_USE:
            begin
                if (!hit_reg)
                begin
                    ex_status = STS_NOT_FOUND;
                end else
                begin
                    ex_report = 1'b1;
                    if ((op_reg == OP_SEND_UPD || op_reg == OP_RECV_UPD) ? grow_ok : shrink_ok)
                    begin
                        ram_wr.en = exec_go;
                        if (op_reg == OP_SEND_UPD)
                        begin
                            ex_row.send_win = win_sum[WIN_W-1:0];
                        end else if (op_reg == OP_RECV_UPD)
                        begin
                            ex_row.recv_win = win_sum[WIN_W-1:0];
                        end else if (op_reg == OP_SEND_USE)
                        begin
                            ex_row.send_win = win_diff;
                        end else
                        begin
                            ex_row.recv_win = win_diff;
                        end
                    end else
                    begin
                        ex_status = STS_FLOW_ERR;
                    end
                end
            end
            OP_CONN_SEND_UPD, OP_CONN_RECV_UPD, OP_CONN_SEND_USE, OP_CONN_RECV_USE:
            begin
                ex_conn = 1'b1;
                if ((op_reg == OP_CONN_SEND_UPD || op_reg == OP_CONN_RECV_UPD)
                    ? grow_ok : shrink_ok)
                begin
                    if (op_reg == OP_CONN_SEND_UPD)
                    begin
                        conn_send_next = win_sum[WIN_W-1:0];
                    end else if (op_reg == OP_CONN_RECV_UPD)
                    begin
                        conn_recv_next = win_sum[WIN_W-1:0];
                    end else if (op_reg == OP_CONN_SEND_USE)
                    begin
                        conn_send_next = win_diff;
                    end else
                    begin
                        conn_recv_next = win_diff;
                    end
                end else
                begin
                    ex_status = STS_FLOW_ERR;
                end
            end
            OP_SCHEDULE:
            begin
                if (best_found_reg)
                begin
                    ex_row    = best_row_reg;
                    ex_report = 1'b1;
                end else
                begin
                    ex_status = STS_NOTHING;
                end
            end
            OP_LOOKUP:
            begin
                if (hit_reg)
                begin
                    ex_report = 1'b1;
                end else
                begin
                    ex_status = STS_NOT_FOUND;
                end
            end
            default:
            begin
                ex_status = STS_OK;
            end
        endcase
        ram_wr.data = ex_row;
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end else
        begin
            state_reg <= state_next;
        end
    end

    // Control registers: sweep counter, table bits, windows and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_cnt_reg    <= '0;
            rd_idx_reg       <= '0;
            rd_vld_reg       <= 1'b0;
            valid_reg        <= '0;
            queued_reg       <= '0;
            stream_count_reg <= '0;
            dirty_reg        <= 1'b0;
            conn_send_reg    <= CONN_WIN_RESET;
            conn_recv_reg    <= CONN_WIN_RESET;
            max_streams_reg  <= MAX_STREAMS_RESET;
            init_win_reg     <= INIT_WIN_RESET;
            res_valid_reg    <= 1'b0;
            hit_reg          <= 1'b0;
            free_found_reg   <= 1'b0;
            best_found_reg   <= 1'b0;
        end else
        begin
            rd_vld_reg <= issue_en;
            if (issue_en)
            begin
                rd_idx_reg    <= issue_cnt_reg[IDX_W-1:0];
                issue_cnt_reg <= issue_cnt_reg + CNT_W'(1);
            end
            if (sweep_last)
            begin
                issue_cnt_reg <= '0;
            end

            if (cmd.valid && cmd_ready)
            begin
                hit_reg        <= 1'b0;
                free_found_reg <= 1'b0;
                best_found_reg <= 1'b0;
                // A pending rebuild puts every live stream back in the queue.
                if (op_t'(cmd.op) == OP_SCHEDULE && dirty_reg)
                begin
                    queued_reg <= valid_reg;
                    dirty_reg  <= 1'b0;
                end
            end

            if (state_reg == S_FIND && rd_vld_reg)
            begin
                if (vbit && rd_data.id == id_reg && !hit_reg)
                begin
                    hit_reg <= 1'b1;
                end
                if (!vbit && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
            end

            if (state_reg == S_SCHED_BEST && rd_vld_reg && qbit && vbit && can_send(rd_data)
                && (!best_found_reg || ranks_ahead(rd_data, best_row_reg)))
            begin
                best_found_reg <= 1'b1;
            end

            // Drop the chosen entry, everything ranked ahead of it and any invalid entry, or all if none sends.
            if (state_reg == S_SCHED_DROP && rd_vld_reg && qbit)
            begin
                if (!best_found_reg || !vbit || rd_idx_reg == best_idx_reg
                    || ranks_ahead(rd_data, best_row_reg))
                begin
                    queued_reg[rd_idx_reg] <= 1'b0;
                end
            end

            if (exec_go)
            begin
                res_valid_reg <= 1'b1;
                if (ex_create)
                begin
                    valid_reg[free_idx_reg]  <= 1'b1;
                    queued_reg[free_idx_reg] <= 1'b1;
                    stream_count_reg         <= stream_count_reg + CNT_W'(1);
                end
                if (ex_remove)
                begin
                    valid_reg[hit_idx_reg]  <= 1'b0;
                    queued_reg[hit_idx_reg] <= 1'b0;
                    if (stream_count_reg != '0)
                    begin
                        stream_count_reg <= stream_count_reg - CNT_W'(1);
                    end
                end
                if (ex_dirty)
                begin
                    dirty_reg <= 1'b1;
                end
                conn_send_reg <= conn_send_next;
                conn_recv_reg <= conn_recv_next;
            end else if (res_valid_reg && res.ready)
            begin
                res_valid_reg <= 1'b0;
            end

            if (cfg_write)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_MAX_STREAMS:
                    begin
                        max_streams_reg <= cfg_data[6:0];
                    end
                    CFG_INIT_WINDOW:
                    begin
                        init_win_reg <= cfg_data;
                    end
                    CFG_CONN_WINDOW:
                    begin
                        conn_send_reg <= cfg_data;
                        conn_recv_reg <= cfg_data;
                    end
                    default:
                    begin
                        max_streams_reg <= max_streams_reg;
                    end
                endcase
            end
        end
    end

    // Payload registers: command fields, sweep captures and the result item
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd_ready)
        begin
            op_reg     <= op_t'(cmd.op);
            id_reg     <= cmd.flow_id;
            amount_reg <= cmd.amount;
            nst_reg    <= cmd.new_state;
            dep_reg    <= cmd.dependency;
            wt_reg     <= cmd.weight;
            ex_reg     <= cmd.exclusive;
        end
        if (state_reg == S_FIND && rd_vld_reg)
        begin
            if (vbit && rd_data.id == id_reg && !hit_reg)
            begin
                hit_idx_reg <= rd_idx_reg;
                row_reg     <= rd_data;
            end
            if (!vbit && !free_found_reg)
            begin
                free_idx_reg <= rd_idx_reg;
            end
        end
        if (state_reg == S_SCHED_BEST && rd_vld_reg && qbit && vbit && can_send(rd_data)
            && (!best_found_reg || ranks_ahead(rd_data, best_row_reg)))
        begin
            best_idx_reg <= rd_idx_reg;
            best_row_reg <= rd_data;
        end
        if (exec_go)
        begin
            res_status_reg <= ex_status;
            res_id_reg     <= ex_report ? ex_row.id : '0;
            res_state_reg  <= ex_report ? ex_row.state : '0;
            res_send_reg   <= ex_conn ? conn_send_next : (ex_report ? ex_row.send_win : '0);
            res_recv_reg   <= ex_conn ? conn_recv_next : (ex_report ? ex_row.recv_win : '0);
        end
    end

endmodule

/* sim/tb_cmd_if.sv */
// Testbench-side copy is not needed: the RTL interfaces are used directly.
// This file holds the small helper interface that groups the configuration write port.
// Depends on stfp_pkg.
interface tb_cfg_if;
    logic                            write;
    logic [stfp_pkg::CFG_IDX_W-1:0]  index;
    logic [stfp_pkg::CFG_DATA_W-1:0] data;
endinterface

/* sim/testbench.sv */
// Self-checking testbench of the stream table block with flow control and priority
// scheduling. Depends on stfp_pkg, stfp_cmd_if, stfp_res_if and tb_cfg_if.
module testbench;
    import stfp_pkg::*;

    localparam int NSLOT = 64;
    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;

    stfp_cmd_if cmd();
    stfp_res_if res();
    tb_cfg_if   cfg();

    stream_table_flow_priority_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .res       (res),
        .cfg_write (cfg.write),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data)
    );

    // Clock with a period of 8 time units.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    typedef struct packed {
        logic [2:0]  status;
        logic [30:0] id;
        logic [2:0]  state;
        logic [30:0] send_win;
        logic [30:0] recv_win;
    } answer_t;

    // Shadow copy of the stream table, kept in step with every accepted item.
    logic        sh_valid [NSLOT];
    logic        sh_queued[NSLOT];
    entry_t      sh_entry [NSLOT];
    int          sh_count;
    logic [30:0] sh_conn_send;
    logic [30:0] sh_conn_recv;
    logic        sh_dirty;
    logic [6:0]  sh_max_streams;
    logic [30:0] sh_init_win;

    answer_t expected_answers[$];
    // Ids that were handed out to streams, so that random commands hit live entries.
    logic [30:0] id_pool[$];

    int mismatches;
    int idle_cycles;
    logic timed_out;
    int res_hold;       // a long receiver hold-off requested by the pressure test
    logic res_hold_active;
    int res_wait;       // cycles the receiver still waits before the next item

    function automatic int find_stream(logic [30:0] id);
        for (int i = 0; i < NSLOT; i++)
        begin
            if (sh_valid[i] && sh_entry[i].id == id)
                return i;
        end
        return -1;
    endfunction

    function automatic logic served_first(int a, int b);
        if (sh_entry[a].dep != sh_entry[b].dep)
            return sh_entry[a].dep < sh_entry[b].dep;
        if (sh_entry[a].weight != sh_entry[b].weight)
            return sh_entry[a].weight > sh_entry[b].weight;
        if (sh_entry[a].excl != sh_entry[b].excl)
            return sh_entry[a].excl;
        return sh_entry[a].id < sh_entry[b].id;
    endfunction

    function automatic answer_t entry_answer(logic [2:0] st, int i);
        answer_t a;
        a = '0;
        a.status = st;
        if (i >= 0)
        begin
            a.id       = sh_entry[i].id;
            a.state    = sh_entry[i].state;
            a.send_win = sh_entry[i].send_win;
            a.recv_win = sh_entry[i].recv_win;
        end
        return a;
    endfunction

    // Grows a window unless the sum would pass the 31-bit maximum.
    function automatic logic window_grow(inout logic [30:0] w, input logic [30:0] inc);
        logic [31:0] s;
        s = {1'b0, w} + {1'b0, inc};
        if (s > 32'h7FFF_FFFF)
            return 1'b0;
        w = s[30:0];
        return 1'b1;
    endfunction

    function automatic logic window_shrink(inout logic [30:0] w, input logic [30:0] n);
        if (n > w)
            return 1'b0;
        w = w - n;
        return 1'b1;
    endfunction

    // Works out the answer to one command and updates the shadow table.
    function automatic answer_t table_predict(logic [3:0] op, logic [30:0] id, logic [30:0] amt,
                                              logic [2:0] nst, logic [30:0] dep,
                                              logic [7:0] wt, logic ex);
        answer_t a;
        int i;
        int best;
        int lim;
        logic ok;
        logic [30:0] w;
        a = '0;
        ok = 1'b1;
        if (op == OP_CREATE)
        begin
            lim = (sh_max_streams < NSLOT) ? sh_max_streams : NSLOT;
            i = find_stream(id);
            if (i >= 0)
                return entry_answer(STS_DUPLICATE, i);
            if (sh_count >= lim)
                return entry_answer(STS_TOO_MANY, -1);
            i = -1;
            for (int j = NSLOT - 1; j >= 0; j--)
            begin
                if (!sh_valid[j])
                    i = j;
            end
            if (i < 0)
                return entry_answer(STS_TOO_MANY, -1);
            sh_valid[i]  = 1'b1;
            sh_queued[i] = 1'b1;
            sh_entry[i].id       = id;
            sh_entry[i].state    = SS_IDLE;
            sh_entry[i].send_win = sh_init_win;
            sh_entry[i].recv_win = sh_init_win;
            sh_entry[i].dep      = '0;
            sh_entry[i].weight   = DEFAULT_WEIGHT;
            sh_entry[i].excl     = 1'b0;
            sh_count++;
            return entry_answer(STS_OK, i);
        end
        if (op >= OP_REMOVE && op <= OP_RECV_USE)
        begin
            i = find_stream(id);
            if (i < 0)
                return entry_answer(STS_NOT_FOUND, -1);
            case (op)
                OP_REMOVE:
                begin
                    a = entry_answer(STS_OK, i);
                    sh_valid[i]  = 1'b0;
                    sh_queued[i] = 1'b0;
                    if (sh_count > 0)
                        sh_count--;
                    sh_dirty = 1'b1;
                    return a;
                end
                OP_SET_STATE: sh_entry[i].state = (nst > SS_CLOSED) ? SS_CLOSED : nst;
                OP_SET_PRIO:
                begin
                    sh_entry[i].dep    = dep;
                    sh_entry[i].weight = wt;
                    sh_entry[i].excl   = ex;
                    sh_dirty = 1'b1;
                end
                OP_SEND_UPD:
                begin
                    w = sh_entry[i].send_win;
                    ok = window_grow(w, amt);
                    sh_entry[i].send_win = w;
                end
                OP_RECV_UPD:
                begin
                    w = sh_entry[i].recv_win;
                    ok = window_grow(w, amt);
                    sh_entry[i].recv_win = w;
                end
                OP_SEND_USE:
                begin
                    w = sh_entry[i].send_win;
                    ok = window_shrink(w, amt);
                    sh_entry[i].send_win = w;
                end
                default:
                begin
                    w = sh_entry[i].recv_win;
                    ok = window_shrink(w, amt);
                    sh_entry[i].recv_win = w;
                end
            endcase
            return entry_answer(ok ? STS_OK : STS_FLOW_ERR, i);
        end
        if (op >= OP_CONN_SEND_UPD && op <= OP_CONN_RECV_USE)
        begin
            case (op)
                OP_CONN_SEND_UPD: ok = window_grow(sh_conn_send, amt);
                OP_CONN_RECV_UPD: ok = window_grow(sh_conn_recv, amt);
                OP_CONN_SEND_USE: ok = window_shrink(sh_conn_send, amt);
                default:          ok = window_shrink(sh_conn_recv, amt);
            endcase
            a.status   = ok ? STS_OK : STS_FLOW_ERR;
            a.send_win = sh_conn_send;
            a.recv_win = sh_conn_recv;
            return a;
        end
        if (op == OP_SCHEDULE)
        begin
            if (sh_dirty)
            begin
                for (int j = 0; j < NSLOT; j++)
                    sh_queued[j] = sh_valid[j];
                sh_dirty = 1'b0;
            end
            best = -1;
            for (int j = 0; j < NSLOT; j++)
            begin
                if (sh_queued[j] && sh_valid[j]
                    && (sh_entry[j].state == SS_OPEN || sh_entry[j].state == SS_HALF_REMOTE)
                    && (best < 0 || served_first(j, best)))
                    best = j;
            end
            // Everything ranked ahead of the winner was passed over and leaves the queue.
            for (int j = 0; j < NSLOT; j++)
            begin
                if (sh_queued[j]
                    && (best < 0 || !sh_valid[j] || j == best || served_first(j, best)))
                    sh_queued[j] = 1'b0;
            end
            return entry_answer((best < 0) ? STS_NOTHING : STS_OK, best);
        end
        if (op == OP_LOOKUP)
        begin
            i = find_stream(id);
            return entry_answer((i < 0) ? STS_NOT_FOUND : STS_OK, i);
        end
        return a;
    endfunction

    task automatic table_reset_shadow();
        for (int i = 0; i < NSLOT; i++)
        begin
            sh_valid[i]  = 1'b0;
            sh_queued[i] = 1'b0;
            sh_entry[i]  = '0;
        end
        sh_count       = 0;
        sh_dirty       = 1'b0;
        sh_max_streams = MAX_STREAMS_RESET;
        sh_init_win    = INIT_WIN_RESET;
        sh_conn_send   = CONN_WIN_RESET;
        sh_conn_recv   = CONN_WIN_RESET;
    endtask

    // Sends one command item after a gap given by the caller and records what it must answer.
    // With no gap the next item follows straight on, so valid stays high.
    task automatic send_command(logic [3:0] op, logic [30:0] id, logic [30:0] amt,
                                logic [2:0] nst, logic [30:0] dep, logic [7:0] wt,
                                logic ex, int gap);
        if (gap > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd.valid      <= 1'b1;
        cmd.op         <= op;
        cmd.flow_id    <= id;
        cmd.amount     <= amt;
        cmd.new_state  <= nst;
        cmd.dependency <= dep;
        cmd.weight     <= wt;
        cmd.exclusive  <= ex;
        do
            @(posedge clk);
        while (!cmd.ready);
        expected_answers.push_back(table_predict(op, id, amt, nst, dep, wt, ex));
        if (op == OP_CREATE)
            id_pool.push_back(id);
    endtask

    task automatic send_simple(logic [3:0] op, logic [30:0] id, logic [30:0] amt);
        send_command(op, id, amt, 3'd0, 31'd0, 8'd0, 1'b0, 0);
    endtask

    task automatic wait_drained();
        cmd.valid <= 1'b0;
        while (expected_answers.size() != 0 && !timed_out)
            @(posedge clk);
        repeat (2 * NSLOT + 8) @(posedge clk);
    endtask

    // Configuration is only written with the block idle.
    task automatic write_register(cfg_idx_t idx, logic [30:0] value);
        wait_drained();
        cfg.write <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        cfg.write <= 1'b0;
        case (idx)
            CFG_MAX_STREAMS: sh_max_streams = value[6:0];
            CFG_INIT_WINDOW: sh_init_win = value;
            default:
            begin
                sh_conn_send = value;
                sh_conn_recv = value;
            end
        endcase
    endtask

    function automatic logic [30:0] pick_id();
        int r;
        r = $urandom_range(0, 9);
        if (id_pool.size() != 0 && r < 8)
            return id_pool[$urandom_range(0, id_pool.size() - 1)];
        if (r == 8)
            return 31'($urandom_range(1, 40));
        return 31'($urandom);
    endfunction

    function automatic logic [30:0] pick_amount();
        case ($urandom_range(0, 5))
            0: return 31'd0;
            1: return 31'h7FFF_FFFF;
            2: return 31'($urandom);
            default: return 31'($urandom_range(0, 70000));
        endcase
    endfunction

    // Directed extremes: every operation, duplicates, window limits,
    // out-of-range states and the unused op codes.
    task automatic test_directed();
        send_simple(OP_SCHEDULE, 31'd0, 31'd0);
        send_simple(OP_LOOKUP, 31'd5, 31'd0);
        send_simple(OP_CREATE, 31'h7FFF_FFFF, 31'd0);
        send_simple(OP_CREATE, 31'd0, 31'd0);
        send_simple(OP_CREATE, 31'd0, 31'd0);
        send_simple(OP_SEND_UPD, 31'h7FFF_FFFF, 31'h7FFF_0000);
        send_simple(OP_SEND_UPD, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_simple(OP_RECV_UPD, 31'd0, 31'd10);
        send_simple(OP_SEND_USE, 31'd0, 31'h7FFF_FFFF);
        send_simple(OP_RECV_USE, 31'd0, 31'd65545);
        send_command(OP_SET_STATE, 31'd0, 31'd0, 3'd7, 31'd0, 8'd0, 1'b0, 0);
        send_command(OP_SET_STATE, 31'h7FFF_FFFF, 31'd0, SS_OPEN, 31'd0, 8'd0, 1'b0, 0);
        send_command(OP_SET_PRIO, 31'h7FFF_FFFF, 31'd0, 3'd0, 31'h7FFF_FFFF, 8'hFF, 1'b1, 0);
        send_simple(OP_SCHEDULE, 31'd0, 31'd0);
        send_simple(OP_SCHEDULE, 31'd0, 31'd0);
        send_simple(OP_CONN_SEND_UPD, 31'd0, 31'h7FFF_FFFF);
        send_simple(OP_CONN_RECV_UPD, 31'd0, 31'd1);
        send_simple(OP_CONN_SEND_USE, 31'd0, 31'd65535);
        send_simple(OP_CONN_RECV_USE, 31'd0, 31'h7FFF_FFFF);
        send_simple(4'd14, 31'd3, 31'd3);
        send_simple(4'd15, 31'd3, 31'd3);
        send_simple(OP_REMOVE, 31'd0, 31'd0);
        send_simple(OP_REMOVE, 31'd0, 31'd0);
        send_simple(OP_LOOKUP, 31'h7FFF_FFFF, 31'd0);
    endtask

    // A small limit on the table so that the full case comes up often.
    task automatic test_table_full();
        write_register(CFG_MAX_STREAMS, 31'd2);
        write_register(CFG_INIT_WINDOW, 31'h7FFF_FFFF);
        for (int k = 0; k < 4; k++)
            send_simple(OP_CREATE, 31'd100 + k, 31'd0);
        write_register(CFG_MAX_STREAMS, 31'd0);
        send_simple(OP_CREATE, 31'd200, 31'd0);
        write_register(CFG_MAX_STREAMS, 31'd127);
        write_register(CFG_INIT_WINDOW, 31'd0);
        write_register(CFG_CONN_WINDOW, 31'd0);
        send_simple(OP_CONN_SEND_USE, 31'd0, 31'd1);
        send_simple(OP_SEND_UPD, 31'd100, 31'd1);
        write_register(CFG_CONN_WINDOW, 31'h7FFF_FFFF);
        send_simple(OP_CONN_RECV_UPD, 31'd0, 31'd1);
    endtask

    // Random commands, biased towards live streams so that the scheduler has work.
    task automatic test_random(int count);
        logic [3:0] op;
        int r;
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 14)       op = OP_CREATE;
            else if (r < 20)  op = OP_REMOVE;
            else if (r < 32)  op = OP_SET_STATE;
            else if (r < 42)  op = OP_SET_PRIO;
            else if (r < 78)  op = 4'($urandom_range(OP_SEND_UPD, OP_CONN_RECV_USE));
            else if (r < 92)  op = OP_SCHEDULE;
            else if (r < 98)  op = OP_LOOKUP;
            else              op = 4'($urandom_range(14, 15));
            send_command(op, pick_id(), pick_amount(), 3'($urandom_range(0, 7)),
                         ($urandom_range(0, 1) != 0) ? 31'($urandom_range(0, 3))
                                                     : 31'($urandom),
                         8'($urandom), 1'($urandom), $urandom_range(0, 16));
        end
    endtask

    // The receiver stops for a long stretch while commands keep coming,
    // then the sender waits until every answer is in.
    task automatic test_backpressure();
        res_hold = 600;
        res_hold_active = 1'b1;
        for (int k = 0; k < 6; k++)
            send_simple(OP_LOOKUP, pick_id(), 31'd0);
        wait_drained();
    endtask

    // Receiver side: draws a random wait after each item, or holds off for a long
    // stretch on request.
    always @(posedge clk)
    begin
        int draw;
        if (!rst_n)
        begin
            res.ready <= 1'b0;
            res_wait  <= 0;
        end
        else if (res_hold_active)
        begin
            res.ready <= 1'b0;
            if (res_hold == 0)
                res_hold_active <= 1'b0;
            else
                res_hold <= res_hold - 1;
        end
        else if (res.valid && res.ready)
        begin
            draw = $urandom_range(0, 16);
            res_wait  <= draw;
            res.ready <= (draw == 0);
        end
        else if (res_wait > 1)
        begin
            res.ready <= 1'b0;
            res_wait  <= res_wait - 1;
        end
        else
        begin
            res.ready <= 1'b1;
            res_wait  <= 0;
        end
    end

    // Answer checker.
    always @(posedge clk)
    begin
        answer_t got;
        answer_t want;
        if (rst_n && res.valid && res.ready)
        begin
            got = {res.status, res.result_id, res.result_state, res.send_window,
                   res.recv_window};
            if (expected_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected item: %h", got);
            end
            else
            begin
                want = expected_answers.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: status %0d/%0d id %h/%h state %0d/%0d send %h/%h recv %h/%h",
                                 want.status, got.status, want.id, got.id, want.state,
                                 got.state, want.send_win, got.send_win, want.recv_win,
                                 got.recv_win);
                end
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge clk)
    begin
        if ((cmd.valid && cmd.ready) || (res.valid && res.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out <= 1'b1;
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        mismatches      = 0;
        idle_cycles     = 0;
        timed_out       = 1'b0;
        res_hold        = 0;
        res_hold_active = 1'b0;
        rst_n           = 1'b0;
        cmd.valid       = 1'b0;
        cmd.op          = '0;
        cmd.flow_id     = '0;
        cmd.amount      = '0;
        cmd.new_state   = '0;
        cmd.dependency  = '0;
        cmd.weight      = '0;
        cmd.exclusive   = 1'b0;
        cfg.write       = 1'b0;
        cfg.index       = '0;
        cfg.data        = '0;
        table_reset_shadow();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_table_full();
        write_register(CFG_MAX_STREAMS, 31'd64);
        write_register(CFG_INIT_WINDOW, 31'd65535);
        test_random(400);
        test_backpressure();
        write_register(CFG_MAX_STREAMS, 31'd5);
        write_register(CFG_CONN_WINDOW, 31'd1000);
        test_random(440);

        wait_drained();
        if (mismatches == 0 && expected_answers.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
